FILE: src/sphere_frustum_cull_assert.svh
// ----------------------------------------------------------------------------
// Sphere frustum cull assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SPHERE_FRUSTUM_CULL_ASSERT_SVH
`define SPHERE_FRUSTUM_CULL_ASSERT_SVH

// same-cycle implication
`define SFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Types and constants shared by the sphere frustum cull cells and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

  localparam int PLANE_MAX_DEF = 6;
  localparam int PLANE_REGS    = 6;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE0 = 3'd1;

  localparam logic [2:0] ACTIVE_RESET = 3'd6;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic [2:0]            active;
  } sfc_cfg_t;

  // sphere travelling down the chain, radius already clamped
  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] cz;
    logic [14:0] r;
    logic        vis;
  } sfc_item_t;

endpackage

`default_nettype wire

FILE: src/sfc_cell.sv
// ----------------------------------------------------------------------------
// sfc_cell
// One plane of the cull chain: holds its plane register, forms the products
// in a first stage and the signed sum and sign test in a second stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_cell #(
  parameter int ID = 0
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire sfc_pkg::sfc_cfg_t    cfg,
  input  wire                       up_valid,
  input  wire sfc_pkg::sfc_item_t   up_item,
  output logic                      up_ready,
  output logic                      dn_valid,
  output sfc_pkg::sfc_item_t        dn_item,
  input  wire                       dn_ready
);

  localparam logic [sfc_pkg::CFG_IDX_W-1:0] REG_IDX =
    sfc_pkg::CFG_IDX_W'(int'(sfc_pkg::CFG_PLANE0) + ID);
  localparam bit HAS_REG = (ID < sfc_pkg::PLANE_REGS);

  logic [63:0] plane;

  logic               a_valid;
  sfc_pkg::sfc_item_t a_item;
  logic signed [31:0] p0;
  logic signed [31:0] p1;
  logic signed [31:0] p2;
  logic signed [17:0] dr;

  logic               en_a;
  logic               en_b;
  logic               act;
  logic [34:0]        sum;

  assign en_b     = !dn_valid || dn_ready;
  assign en_a     = !a_valid || en_b;
  assign up_ready = en_a;
  assign act      = (int'(cfg.active) > ID);

  // n.c + (d + r) * 2^14, negative means the sphere lies outside this plane
  assign sum = {{3{p0[31]}}, p0} + {{3{p1[31]}}, p1} + {{3{p2[31]}}, p2}
             + {{3{dr[17]}}, dr, 14'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      plane <= '0;
    end else if (HAS_REG && cfg.we && cfg.index == REG_IDX) begin
      plane <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && up_valid) begin
      a_item <= up_item;
      p0 <= $signed(plane[15:0])  * $signed(up_item.cx);
      p1 <= $signed(plane[31:16]) * $signed(up_item.cy);
      p2 <= $signed(plane[47:32]) * $signed(up_item.cz);
      dr <= $signed({{2{plane[63]}}, plane[63:48]}) + $signed({3'b0, up_item.r});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en_b) begin
      dn_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && a_valid) begin
      dn_item <= '{cx: a_item.cx, cy: a_item.cy, cz: a_item.cz, r: a_item.r,
                   vis: a_item.vis & ~(act & sum[34])};
    end
  end

endmodule

`default_nettype wire

FILE: src/sphere_frustum_cull.sv
// Path: two register stages per plane cell (multiply, then sum), then the
// registered output beat.
// Throughput: one sphere per cycle while out_stall is low; the multiply and
// sum stages of each cell pass a beat when the stage downstream can take it.
// Reset: active_planes returns to 6, all planes to zero, the chain empties.
// ----------------------------------------------------------------------------
// sphere_frustum_cull
// Bounding sphere visibility test against up to PLANE_MAX clipping planes,
// run as a chain of plane cells with a registered output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_frustum_cull #(
  parameter int PLANE_MAX = sfc_pkg::PLANE_MAX_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire [sfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [sfc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire signed [15:0]                center_x,
  input  wire signed [15:0]                center_y,
  input  wire signed [15:0]                center_z,
  input  wire signed [15:0]                radius,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             visible
);

  logic [2:0]         active_planes;
  sfc_pkg::sfc_cfg_t  cfg;

  logic [PLANE_MAX:0]  link_valid;
  logic [PLANE_MAX:0]  link_ready;
  sfc_pkg::sfc_item_t  link_item [PLANE_MAX+1];

  logic en_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_planes <= sfc_pkg::ACTIVE_RESET;
    end else if (cfg_we && cfg_index == sfc_pkg::CFG_ACTIVE) begin
      active_planes <= cfg_data[2:0];
    end
  end

  assign cfg.we     = cfg_we;
  assign cfg.index  = cfg_index;
  assign cfg.data   = cfg_data;
  assign cfg.active = active_planes;

  // negative radius clamps to zero
  assign link_valid[0]    = in_valid;
  assign link_item[0].cx  = center_x;
  assign link_item[0].cy  = center_y;
  assign link_item[0].cz  = center_z;
  assign link_item[0].r   = radius[15] ? 15'd0 : radius[14:0];
  assign link_item[0].vis = 1'b1;
  assign in_stall         = !link_ready[0];

  for (genvar i = 0; i < PLANE_MAX; i++) begin : g_cell
    sfc_cell #(
      .ID (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cfg      (cfg),
      .up_valid (link_valid[i]),
      .up_item  (link_item[i]),
      .up_ready (link_ready[i]),
      .dn_valid (link_valid[i+1]),
      .dn_item  (link_item[i+1]),
      .dn_ready (link_ready[i+1])
    );
  end

  assign en_out                = !out_valid || !out_stall;
  assign link_ready[PLANE_MAX] = en_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= link_valid[PLANE_MAX];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && link_valid[PLANE_MAX]) begin
      visible <= link_item[PLANE_MAX].vis;
    end
  end

`include "sphere_frustum_cull_assert.svh"

  // an empty output register frees every stage of the chain
  `SFC_ASSERT_NOW(a_empty_no_stall, !out_valid, !in_stall, "input stalled with output empty")
  `SFC_ASSERT_NEXT(a_last_lands, link_valid[PLANE_MAX] && en_out, out_valid, "beat lost at output")
  `SFC_ASSERT_NEXT(a_drain, out_valid && !out_stall && !link_valid[PLANE_MAX], !out_valid,
                   "result beat repeated")

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sphere_frustum_cull. Directed and random spheres run
// against many plane sets and active counts, with random source gaps and sink
// stalls. Each visible flag is checked against an exact in-bench plane test.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_PLANES     = 6;
  localparam int LATENCY        = 2 * NUM_PLANES + 1;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PRINT_LIMIT    = 50;
  localparam int RAND_PHASES    = 8;
  localparam int SPHERES_PER_PHASE = 180;
  localparam int ACT_SEQ [RAND_PHASES] = '{6, 1, 3, 0, 7, 2, 5, 4};
  // index 7 maps to no register; writes there must be dropped
  localparam logic [sfc_pkg::CFG_IDX_W-1:0] CFG_NONE = 3'd7;

  typedef struct {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic signed [15:0] r;
  } sphere_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [sfc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sfc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic signed [15:0]             center_x = '0;
  logic signed [15:0]             center_y = '0;
  logic signed [15:0]             center_z = '0;
  logic signed [15:0]             radius = '0;
  logic                           out_stall = 1'b0;
  wire                            in_stall;
  wire                            out_valid;
  wire                            visible;

  // bench copy of the register file
  logic [2:0]  active_mdl;
  logic [63:0] plane_mdl [NUM_PLANES];

  sphere_t sphere_q [$];
  logic    exp_visible_q [$];
  sphere_t held;
  int      src_idle_pct = 0;
  int      sink_stall_pct = 0;
  int      fail_count = 0;
  int      quiet_cycles = 0;

  sphere_frustum_cull u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .center_x  (center_x),
    .center_y  (center_y),
    .center_z  (center_z),
    .radius    (radius),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .visible   (visible)
  );

  always #1 clk = ~clk;

  // signed distance of the sphere center from a plane, Q.14
  function automatic longint plane_dist(logic [63:0] p, sphere_t s);
    return longint'($signed(p[15:0])) * s.cx
         + longint'($signed(p[31:16])) * s.cy
         + longint'($signed(p[47:32])) * s.cz
         + longint'($signed(p[63:48])) * 16384;
  endfunction

  function automatic logic sphere_visible(sphere_t s);
    longint rad;
    int     n;
    logic   vis;
    rad = (s.r < 0) ? 0 : s.r;
    n = (active_mdl > NUM_PLANES) ? NUM_PLANES : active_mdl;
    vis = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (plane_dist(plane_mdl[i], s) < -(rad * 16384)) vis = 1'b0;
    end
    return vis;
  endfunction

  function automatic logic [63:0] plane_word(int nx, int ny, int nz, int d);
    return {d[15:0], nz[15:0], ny[15:0], nx[15:0]};
  endfunction

  function automatic logic [63:0] rand_plane();
    logic [15:0] n [3];
    int          pick;
    n[0] = '0;
    n[1] = '0;
    n[2] = '0;
    case ($urandom_range(2))
      0: begin
        // axis-aligned, unit or extreme magnitude
        pick = $urandom_range(3);
        n[$urandom_range(2)] = (pick == 0) ? 16'h4000 : (pick == 1) ? 16'hc000 :
                               (pick == 2) ? 16'h7fff : 16'h8000;
      end
      1: return {$urandom, $urandom};
      default: begin
        for (int i = 0; i < 3; i++) n[i] = 16'(int'($urandom_range(8191)) - 4096);
      end
    endcase
    return {16'($urandom), n[2], n[1], n[0]};
  endfunction

  function automatic sphere_t rand_sphere();
    sphere_t s;
    longint  tgt;
    int      n;
    n = (active_mdl > NUM_PLANES) ? NUM_PLANES : active_mdl;
    if (n > 0 && $urandom_range(1) == 1) begin
      // put the radius at or just beside the cull threshold of one active plane
      if ($urandom_range(1) == 1) begin
        s.cx = 16'(int'($urandom_range(4095)) - 2048);
        s.cy = 16'(int'($urandom_range(4095)) - 2048);
        s.cz = 16'(int'($urandom_range(4095)) - 2048);
      end else begin
        s.cx = 16'($urandom);
        s.cy = 16'($urandom);
        s.cz = 16'($urandom);
      end
      s.r = '0;
      tgt = -(plane_dist(plane_mdl[$urandom_range(n - 1)], s) >>> 14)
            + int'($urandom_range(4)) - 2;
      s.r = (tgt > 32767) ? 16'sh7fff : (tgt < -32768) ? 16'sh8000 : tgt[15:0];
    end else begin
      s.cx = 16'($urandom);
      s.cy = 16'($urandom);
      s.cz = 16'($urandom);
      s.r  = 16'($urandom);
    end
    return s;
  endfunction

  task automatic add_sphere(int x, int y, int z, int r);
    sphere_t s;
    s.cx = 16'(x);
    s.cy = 16'(y);
    s.cz = 16'(z);
    s.r  = 16'(r);
    sphere_q = {sphere_q, s};
  endtask

  task automatic write_reg(logic [sfc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == sfc_pkg::CFG_ACTIVE) active_mdl = val[2:0];
    else if (idx >= sfc_pkg::CFG_PLANE0 && idx < sfc_pkg::CFG_PLANE0 + NUM_PLANES)
      plane_mdl[idx - sfc_pkg::CFG_PLANE0] = val;
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sampled away from the rising edge so the driver's updates have settled
  task automatic drain();
    while (sphere_q.size() != 0 || in_valid || exp_visible_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic report_error(string msg);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) $display("ERROR t=%0t: %s", $time, msg);
  endtask

  // source side
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) exp_visible_q = {exp_visible_q, sphere_visible(held)};
      if (!in_valid || !in_stall) begin
        if (sphere_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          held = sphere_q.pop_front();
          in_valid <= 1'b1;
          center_x <= held.cx;
          center_y <= held.cy;
          center_z <= held.cz;
          radius   <= held.r;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // sink side, checker and watchdog
  always @(posedge clk) begin
    logic exp_vis;
    if (rst) begin
      out_stall    <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
      if (out_valid && !out_stall) begin
        if (exp_visible_q.size() == 0) begin
          report_error("result beat with no sphere outstanding");
        end else begin
          exp_vis = exp_visible_q.pop_front();
          if (visible !== exp_vis)
            report_error($sformatf("visible %b, expected %b", visible, exp_vis));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("sphere_frustum_cull regression: fail");
        $finish;
      end
    end
  end

  initial begin
    active_mdl = sfc_pkg::ACTIVE_RESET;
    foreach (plane_mdl[i]) plane_mdl[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset planes are all zero and never cull
    add_sphere(-32768, -32768, -32768, -32768);
    add_sphere(32767, 32767, 32767, 32767);
    add_sphere(0, 0, 0, 0);
    add_sphere(-1, -1, -1, -1);
    drain();

    // single plane x >= -r: threshold, negative radius clamp, extremes
    write_reg(sfc_pkg::CFG_ACTIVE, 64'd1);
    write_reg(sfc_pkg::CFG_PLANE0, plane_word(16384, 0, 0, 0));
    end_writes();
    add_sphere(-5, 0, 0, 5);
    add_sphere(-6, 0, 0, 5);
    add_sphere(-5, 0, 0, -3);
    add_sphere(0, 0, 0, -32768);
    add_sphere(-32768, 0, 0, 32767);
    add_sphere(32767, -32768, -32768, 0);
    drain();

    // extreme plane words, count above the plane bound saturates
    write_reg(sfc_pkg::CFG_ACTIVE, 64'd7);
    write_reg(sfc_pkg::CFG_PLANE0, {4{16'h8000}});
    write_reg(sfc_pkg::CFG_PLANE0 + 3'd1, {4{16'h7fff}});
    write_reg(sfc_pkg::CFG_PLANE0 + 3'd2, '1);
    write_reg(sfc_pkg::CFG_PLANE0 + 3'd3, '0);
    write_reg(sfc_pkg::CFG_PLANE0 + 3'd4, plane_word(0, -16384, 0, 100));
    write_reg(sfc_pkg::CFG_PLANE0 + 3'd5, plane_word(0, 0, 32767, -100));
    write_reg(CFG_NONE, '1);
    end_writes();
    add_sphere(-32768, -32768, -32768, 32767);
    add_sphere(32767, 32767, 32767, -32768);
    add_sphere(0, 0, 0, 0);
    add_sphere(-1, 0, 1, 100);
    drain();

    // no active plane: everything visible
    write_reg(sfc_pkg::CFG_ACTIVE, 64'd0);
    end_writes();
    add_sphere(-32768, -32768, -32768, -32768);
    add_sphere(32767, 32767, 32767, 0);
    add_sphere(0, 0, 0, 0);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_reg(sfc_pkg::CFG_ACTIVE, {$urandom, 29'($urandom), 3'(ACT_SEQ[p])});
      for (int i = 0; i < NUM_PLANES; i++)
        write_reg(sfc_pkg::CFG_PLANE0 + 3'(i), rand_plane());
      if ($urandom_range(1) == 1) write_reg(CFG_NONE, {$urandom, $urandom});
      end_writes();
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 83; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 83; end
        default: begin src_idle_pct = 12; sink_stall_pct = 12; end
      endcase
      for (int k = 0; k < SPHERES_PER_PHASE; k++) sphere_q = {sphere_q, rand_sphere()};
      drain();
    end

    repeat (4 * LATENCY) @(posedge clk);
    if (fail_count == 0) $display("sphere_frustum_cull regression: pass");
    else $display("sphere_frustum_cull regression: fail");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/sfc_pkg.sv
src/sfc_cell.sv
src/sphere_frustum_cull.sv
tb/sv/tb_top.sv
